@@ rtl/ssgs_pkg.sv @@
// ============================================================================
// Smagorinsky SGS stress package
// Shared types, constants and fixed-point helpers for the stress unit.
// ============================================================================
package ssgs_pkg;

    // Fraction bits of the fixed-point data values (Q16.16 by default).
    localparam int FRAC_BITS   = 16;
    // One result bit of the square root is settled in each pipeline stage.
    localparam int SQRT_STAGES = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_DIFFS   = 9;
    localparam int NUM_STRESS  = 6;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_TWO_DX = 3'd0,
        REG_INV_TWO_DY = 3'd1,
        REG_INV_TWO_DZ = 3'd2,
        REG_SMAG_COEFF = 3'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [30:0] inv_two_dx;
        logic [30:0] inv_two_dy;
        logic [30:0] inv_two_dz;
        logic [31:0] smag_coeff;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] du_along_x;
        logic signed [31:0] du_along_y;
        logic signed [31:0] du_along_z;
        logic signed [31:0] dv_along_x;
        logic signed [31:0] dv_along_y;
        logic signed [31:0] dv_along_z;
        logic signed [31:0] dw_along_x;
        logic signed [31:0] dw_along_y;
        logic signed [31:0] dw_along_z;
    } in_beat_t;

    typedef struct packed {
        logic        [30:0] eddy_viscosity;
        logic signed [31:0] stress_xx;
        logic signed [31:0] stress_yy;
        logic signed [31:0] stress_zz;
        logic signed [31:0] stress_xy;
        logic signed [31:0] stress_xz;
        logic signed [31:0] stress_yz;
    } out_beat_t;

    // Strain-rate tensor entries, in the order xx, yy, zz, xy, xz, yz.
    typedef logic signed [NUM_STRESS-1:0][31:0] strain_t;

    // Magnitude of a signed 32-bit value; the most negative value maps to 2^31.
    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? (~v + 32'd1) : v;
        return r;
    endfunction

    // Add one half LSB and drop the fraction bits.
    function automatic logic [63:0] round_shift(input logic [63:0] mag);
        logic [63:0] r;
        r = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return r;
    endfunction

    // Build a signed value from sign and magnitude, saturated to 32 bits.
    function automatic logic signed [31:0] sat_signed(input logic neg,
                                                      input logic [63:0] mag);
        logic signed [31:0] r;
        if (neg) begin
            if (mag > 64'h8000_0000) r = 32'sh8000_0000;
            else                     r = -$signed(mag[31:0]);
        end else begin
            if (mag > 64'h7FFF_FFFF) r = 32'sh7FFF_FFFF;
            else                     r = $signed(mag[31:0]);
        end
        return r;
    endfunction

endpackage

@@ rtl/ssgs_grad.sv @@
// ============================================================================
// Gradient and strain stages
// Scales the nine differences by the inverse spacings and forms the strain.
// ============================================================================
module ssgs_grad (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  ssgs_pkg::in_beat_t in_beat,
    input  ssgs_pkg::cfg_t   cfg,
    output logic             valid,
    output ssgs_pkg::strain_t strain
);

    logic [ssgs_pkg::NUM_DIFFS-1:0][31:0] diff;
    logic [ssgs_pkg::NUM_DIFFS-1:0][30:0] inv;
    logic [62:0] mag_reg [ssgs_pkg::NUM_DIFFS];
    logic        neg_reg [ssgs_pkg::NUM_DIFFS];
    logic        va_reg;
    logic        vb_reg;
    logic signed [31:0] grad [ssgs_pkg::NUM_DIFFS];
    logic signed [32:0] sum_xy;
    logic signed [32:0] sum_xz;
    logic signed [32:0] sum_yz;
    ssgs_pkg::strain_t strain_next;
    ssgs_pkg::strain_t strain_reg;

    // Lane order follows the beat; the spacing repeats x, y, z.
    always_comb
    begin
        diff = in_beat;
        for (int i = 0; i < ssgs_pkg::NUM_DIFFS; i++)
        begin
            case (i % 3)
                0:       inv[i] = cfg.inv_two_dx;
                1:       inv[i] = cfg.inv_two_dy;
                default: inv[i] = cfg.inv_two_dz;
            endcase
        end
    end

    // Stage A: magnitude products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ssgs_pkg::NUM_DIFFS; i++)
            begin
                mag_reg[i] <= 63'(ssgs_pkg::abs32(diff[ssgs_pkg::NUM_DIFFS-1-i]))
                              * 63'(inv[i]);
                neg_reg[i] <= diff[ssgs_pkg::NUM_DIFFS-1-i][31];
            end
        end
    end

    // Stage B: round and saturate, then the symmetric strain entries.
    always_comb
    begin
        for (int i = 0; i < ssgs_pkg::NUM_DIFFS; i++)
        begin
            grad[i] = ssgs_pkg::sat_signed(neg_reg[i],
                                           ssgs_pkg::round_shift({1'b0, mag_reg[i]}));
        end
        sum_xy = 33'(grad[1]) + 33'(grad[3]);
        sum_xz = 33'(grad[2]) + 33'(grad[6]);
        sum_yz = 33'(grad[5]) + 33'(grad[7]);
        strain_next[5] = grad[0];
        strain_next[4] = grad[4];
        strain_next[3] = grad[8];
        strain_next[2] = ssgs_pkg::sat_signed(sum_xy[32],
            (64'(sum_xy[32] ? -sum_xy : sum_xy) + 64'd1) >> 1);
        strain_next[1] = ssgs_pkg::sat_signed(sum_xz[32],
            (64'(sum_xz[32] ? -sum_xz : sum_xz) + 64'd1) >> 1);
        strain_next[0] = ssgs_pkg::sat_signed(sum_yz[32],
            (64'(sum_yz[32] ? -sum_yz : sum_yz) + 64'd1) >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            strain_reg <= strain_next;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    assign valid  = vb_reg;
    assign strain = strain_reg;

endmodule

@@ rtl/ssgs_sqsum.sv @@
// ============================================================================
// Square-sum stages
// Squares the strain entries and forms the saturated weighted sum.
// ============================================================================
module ssgs_sqsum (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  ssgs_pkg::strain_t strain_in,
    output logic              valid,
    output logic [63:0]       acc,
    output ssgs_pkg::strain_t strain
);

    logic [63:0] sq_reg [ssgs_pkg::NUM_STRESS];
    logic [63:0] diag_reg;
    logic [63:0] offd_reg;
    logic [63:0] acc_reg;
    logic [66:0] wsum;
    ssgs_pkg::strain_t s1_reg;
    ssgs_pkg::strain_t s2_reg;
    ssgs_pkg::strain_t s3_reg;
    logic [2:0]  v_reg;

    // Weighted sum; every partial square is at most 2^62, so only the end clamps.
    assign wsum = {2'b00, diag_reg, 1'b0} + {1'b0, offd_reg, 2'b00};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ssgs_pkg::NUM_STRESS; i++)
            begin
                sq_reg[i] <= 64'(ssgs_pkg::abs32(strain_in[i]))
                             * 64'(ssgs_pkg::abs32(strain_in[i]));
            end
            s1_reg   <= strain_in;
            diag_reg <= sq_reg[5] + sq_reg[4] + sq_reg[3];
            offd_reg <= sq_reg[2] + sq_reg[1] + sq_reg[0];
            s2_reg   <= s1_reg;
            acc_reg  <= (wsum[66:64] != 3'd0) ? {64{1'b1}} : wsum[63:0];
            s3_reg   <= s2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    assign valid  = v_reg[2];
    assign acc    = acc_reg;
    assign strain = s3_reg;

endmodule

@@ rtl/ssgs_isqrt.sv @@
// ============================================================================
// Pipelined integer square root
// Digit-recurrence root of a 64-bit value, one result bit per stage.
// ============================================================================
module ssgs_isqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [63:0]       radicand,
    input  ssgs_pkg::strain_t strain_in,
    output logic              valid,
    output logic [31:0]       root,
    output ssgs_pkg::strain_t strain
);

    localparam int N = ssgs_pkg::SQRT_STAGES;

    logic [33:0]       rem_reg  [N];
    logic [31:0]       root_reg [N];
    logic [63:0]       x_reg    [N];
    ssgs_pkg::strain_t s_reg    [N];
    logic [N-1:0]      v_reg;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_stage
            logic [33:0]       rem_in;
            logic [31:0]       root_in;
            logic [63:0]       x_in;
            ssgs_pkg::strain_t s_in;
            logic [35:0]       cur;
            logic [35:0]       trial;

            if (g == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign x_in    = radicand;
                assign s_in    = strain_in;
            end else
            begin : g_next
                assign rem_in  = rem_reg[g-1];
                assign root_in = root_reg[g-1];
                assign x_in    = x_reg[g-1];
                assign s_in    = s_reg[g-1];
            end

            // Bring down two radicand bits and try the next root bit.
            assign cur   = {rem_in, x_in[63:62]};
            assign trial = {2'b00, root_in, 2'b01};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (cur >= trial)
                    begin
                        rem_reg[g]  <= 34'(cur - trial);
                        root_reg[g] <= {root_in[30:0], 1'b1};
                    end else
                    begin
                        rem_reg[g]  <= cur[33:0];
                        root_reg[g] <= {root_in[30:0], 1'b0};
                    end
                    x_reg[g] <= {x_in[61:0], 2'b00};
                    s_reg[g] <= s_in;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end else if (en)
        begin
            v_reg <= {v_reg[N-2:0], in_valid};
        end
    end

    assign valid  = v_reg[N-1];
    assign root   = root_reg[N-1];
    assign strain = s_reg[N-1];

endmodule

@@ rtl/ssgs_visc.sv @@
// ============================================================================
// Eddy viscosity and stress stages
// Scales the strain magnitude by the coefficient and forms the six stresses.
// ============================================================================
module ssgs_visc (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [31:0]         smag,
    input  ssgs_pkg::strain_t   strain_in,
    input  logic [31:0]         smag_coeff,
    output logic                valid,
    output ssgs_pkg::out_beat_t beat
);

    logic [63:0]         prod_reg;
    logic [30:0]         nu_reg;
    logic [30:0]         nu2_reg;
    logic [62:0]         sp_reg  [ssgs_pkg::NUM_STRESS];
    logic                neg_reg [ssgs_pkg::NUM_STRESS];
    logic [63:0]         rounded;
    logic [31:0]         nu_wide;
    ssgs_pkg::strain_t   s1_reg;
    ssgs_pkg::strain_t   s2_reg;
    ssgs_pkg::strain_t   res_next;
    ssgs_pkg::out_beat_t beat_reg;
    logic [3:0]          v_reg;

    // Rounded Q0.32 scaling; the sum cannot pass 2^64.
    assign rounded = prod_reg + 64'h8000_0000;
    assign nu_wide = rounded[63:32];

    always_comb
    begin
        for (int i = 0; i < ssgs_pkg::NUM_STRESS; i++)
        begin
            res_next[i] = ssgs_pkg::sat_signed(neg_reg[i],
                              ssgs_pkg::round_shift({sp_reg[i], 1'b0}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 64'(smag_coeff) * 64'(smag);
            s1_reg   <= strain_in;
            nu_reg   <= nu_wide[31] ? 31'h7FFF_FFFF : nu_wide[30:0];
            s2_reg   <= s1_reg;
            for (int i = 0; i < ssgs_pkg::NUM_STRESS; i++)
            begin
                sp_reg[i]  <= 63'(nu_reg) * 63'(ssgs_pkg::abs32(s2_reg[i]));
                neg_reg[i] <= !s2_reg[i][31] && (s2_reg[i] != 32'sd0);
            end
            nu2_reg <= nu_reg;
            beat_reg.eddy_viscosity <= nu2_reg;
            beat_reg.stress_xx      <= res_next[5];
            beat_reg.stress_yy      <= res_next[4];
            beat_reg.stress_zz      <= res_next[3];
            beat_reg.stress_xy      <= res_next[2];
            beat_reg.stress_xz      <= res_next[1];
            beat_reg.stress_yz      <= res_next[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end else if (en)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    assign valid = v_reg[3];
    assign beat  = beat_reg;

endmodule

@@ rtl/smagorinsky_sgs_stress_unit.sv @@
// ============================================================================
// Smagorinsky SGS stress unit
// Streams one grid cell per cycle, while in_stall is low, from velocity
// differences to eddy viscosity and the six subgrid stresses.
// ============================================================================
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid / in_stall     in_beat  (nine differences)
//  out      output     out_valid / out_stall   out_beat (viscosity, stresses)
//  cfg      input      cfg_we                  cfg_index, cfg_wdata
//
// One cell enters each cycle while in_stall is low; each result passes the 32
// square-root stages plus the multiply stages before it reaches the buffer.
// Reset clears all valid bits and loads the default spacings and coefficient.
// The pipeline advances as a whole; a two-entry output buffer lets it keep
// taking beats while a result waits, and in_stall rises only when it fills.
module smagorinsky_sgs_stress_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  ssgs_pkg::in_beat_t               in_beat,
    output logic                             out_valid,
    input  logic                             out_stall,
    output ssgs_pkg::out_beat_t              out_beat,
    input  logic                             cfg_we,
    input  logic [ssgs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_wdata
);

    ssgs_pkg::cfg_t      cfg_reg;
    logic                en;
    logic                g_valid;
    ssgs_pkg::strain_t   g_strain;
    logic                q_valid;
    logic [63:0]         q_acc;
    ssgs_pkg::strain_t   q_strain;
    logic                r_valid;
    logic [31:0]         r_root;
    ssgs_pkg::strain_t   r_strain;
    logic                v_valid;
    ssgs_pkg::out_beat_t v_beat;
    ssgs_pkg::out_beat_t buf0_reg;
    ssgs_pkg::out_beat_t buf1_reg;
    logic [1:0]          count_reg;
    logic                push;
    logic                pop;

    // Configuration registers; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_two_dx <= 31'd3276800;
            cfg_reg.inv_two_dy <= 31'd3276800;
            cfg_reg.inv_two_dz <= 31'd3276800;
            cfg_reg.smag_coeff <= 32'd13915;
        end else if (cfg_we)
        begin
            case (ssgs_pkg::cfg_reg_t'(cfg_index))
                ssgs_pkg::REG_INV_TWO_DX: cfg_reg.inv_two_dx <= cfg_wdata[30:0];
                ssgs_pkg::REG_INV_TWO_DY: cfg_reg.inv_two_dy <= cfg_wdata[30:0];
                ssgs_pkg::REG_INV_TWO_DZ: cfg_reg.inv_two_dz <= cfg_wdata[30:0];
                ssgs_pkg::REG_SMAG_COEFF: cfg_reg.smag_coeff <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The pipeline moves while the output buffer has room.
    assign en       = (count_reg != 2'd2);
    assign in_stall = !en;

    ssgs_grad u_grad (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .in_beat  (in_beat),
        .cfg      (cfg_reg),
        .valid    (g_valid),
        .strain   (g_strain)
    );

    ssgs_sqsum u_sqsum (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (g_valid),
        .strain_in (g_strain),
        .valid     (q_valid),
        .acc       (q_acc),
        .strain    (q_strain)
    );

    ssgs_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid),
        .radicand  (q_acc),
        .strain_in (q_strain),
        .valid     (r_valid),
        .root      (r_root),
        .strain    (r_strain)
    );

    ssgs_visc u_visc (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (r_valid),
        .smag       (r_root),
        .strain_in  (r_strain),
        .smag_coeff (cfg_reg.smag_coeff),
        .valid      (v_valid),
        .beat       (v_beat)
    );

    // Two-entry output buffer; buf0 is the head.
    assign push = en && v_valid;
    assign pop  = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end else
        begin
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            buf0_reg <= (push && count_reg == 2'd1) ? v_beat : buf1_reg;
        end else if (push && count_reg == 2'd0)
        begin
            buf0_reg <= v_beat;
        end
        if (push && ((count_reg == 2'd1 && !pop) || count_reg == 2'd2))
        begin
            buf1_reg <= v_beat;
        end
    end

    assign out_valid = (count_reg != 2'd0);
    assign out_beat  = buf0_reg;

    // The buffer never holds more than two beats.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output buffer overflow");

    // A zero viscosity gives zero stresses.
    a_zero_nu: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_beat.eddy_viscosity == 31'd0) |->
        (out_beat.stress_xx == 32'sd0 && out_beat.stress_yy == 32'sd0 &&
         out_beat.stress_zz == 32'sd0 && out_beat.stress_xy == 32'sd0 &&
         out_beat.stress_xz == 32'sd0 && out_beat.stress_yz == 32'sd0))
        else $error("stress without viscosity");

    // A full buffer stalls the input side.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> (in_stall && !push))
        else $error("push into full buffer");

endmodule
